// ===== design/stc_pkg.sv =====
`default_nettype none

package stc_pkg;

    localparam int CHAR_W    = 8;
    localparam int COL_W     = 8;
    localparam int TAB_SHIFT = 3;

    localparam logic [COL_W-1:0]  COL_MAX  = 8'd255;
    localparam logic [CHAR_W-1:0] CH_EOL   = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    localparam logic ADDR_WHOLE_LINE = 1'b0;

    // one gap-closing job handed to the emitter
    typedef struct packed {
        logic              start;
        logic [CHAR_W-1:0] ch;
        logic [COL_W-1:0]  ocol;
        logic [COL_W-1:0]  dcol;
        logic              ovf;
    } job_t;

endpackage

`default_nettype wire

// ===== design/stc_emitter.sv =====
`default_nettype none

module stc_emitter
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  stc_pkg::job_t                job,
    output logic                         busy,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [stc_pkg::CHAR_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tlast,
    output logic                         m_axis_tuser
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam int STOP_W = stc_pkg::COL_W + 1;
    localparam int HI_W   = stc_pkg::COL_W - stc_pkg::TAB_SHIFT + 1;

    logic                         state_reg, state_next;
    logic [stc_pkg::COL_W-1:0]    ocol_reg, ocol_next;
    logic [stc_pkg::COL_W-1:0]    dcol_reg;
    logic [stc_pkg::CHAR_W-1:0]   ch_reg;
    logic                         ovf_reg;
    logic                         valid_reg, valid_next;
    logic [stc_pkg::CHAR_W-1:0]   data_reg, data_next;
    logic                         last_reg, last_next;
    logic                         user_reg, user_next;

    logic                         advance;
    logic [HI_W-1:0]              stop_hi;
    logic [STOP_W-1:0]            stop;
    logic [STOP_W-1:0]            ocol_inc;
    logic [STOP_W-1:0]            dcol_ext;
    logic                         use_tab;
    logic                         use_space;

    assign advance  = !valid_reg || m_axis_tready;

    // shared step unit: next tab stop and the gap compares
    assign stop_hi  = {1'b0, ocol_reg[stc_pkg::COL_W-1:stc_pkg::TAB_SHIFT]} + HI_W'(1);
    assign stop     = {stop_hi, {stc_pkg::TAB_SHIFT{1'b0}}};
    assign ocol_inc = {1'b0, ocol_reg} + STOP_W'(1);
    assign dcol_ext = {1'b0, dcol_reg};
    assign use_tab  = (stop <= dcol_ext) && (ocol_inc != dcol_ext);
    assign use_space = ocol_reg < dcol_reg;

    always_comb
    begin
        state_next = state_reg;
        ocol_next  = ocol_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (advance)
                begin
                    valid_next = 1'b0;
                end
                if (job.start)
                begin
                    state_next = ST_EMIT;
                    ocol_next  = job.ocol;
                end
            end
            ST_EMIT:
            begin
                if (advance)
                begin
                    valid_next = 1'b1;
                    user_next  = ovf_reg;
                    if (use_tab)
                    begin
                        data_next = stc_pkg::CH_TAB;
                        last_next = 1'b0;
                        ocol_next = stop[stc_pkg::COL_W-1:0];
                    end
                    else if (use_space)
                    begin
                        data_next = stc_pkg::CH_SPACE;
                        last_next = 1'b0;
                        ocol_next = ocol_inc[stc_pkg::COL_W-1:0];
                    end
                    else
                    begin
                        data_next  = ch_reg;
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ocol_reg <= ocol_next;
        data_reg <= data_next;
        last_reg <= last_next;
        user_reg <= user_next;
        if (state_reg == ST_IDLE && job.start)
        begin
            dcol_reg <= job.dcol;
            ch_reg   <= job.ch;
            ovf_reg  <= job.ovf;
        end
    end

    assign busy          = (state_reg == ST_EMIT);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = user_reg;

endmodule

`default_nettype wire

// ===== design/space_to_tab_compressor_unit.sv =====
// Space-to-tab compressor with tab stops every 8 columns. Bytes of a line enter on
// s_axis and the line ends with a zero byte, which is passed through and clears the
// column counters for the next line. Spaces and tabs emit nothing while compressing;
// they advance a pending column. A text byte or the line end makes the block emit
// tabs up to the pending column, then spaces, then the byte itself. While
// compressing, a blank byte keeps s_axis_tready high; any other byte drops it until
// the last of its results is loaded into the output register, as a single
// gap-stepping unit produces one result per cycle while m_axis_tready is high (at
// most 39 results per line gap). Register whole_line (address 0, reset 1) selects
// compression over the whole line, or of leading blanks only with the rest copied
// verbatim. m_axis_tuser reports column saturation at 255 within the current line.
`default_nettype none

module space_to_tab_compressor_unit
(
    input  wire                          clk,
    input  wire                          rst_n,
    // APB configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire                          paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // input bytes
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [stc_pkg::CHAR_W-1:0]   s_axis_tdata,   // [7:0] in_char
    // results
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [stc_pkg::CHAR_W-1:0]   m_axis_tdata,   // [7:0] out_char
    output logic                         m_axis_tlast,
    output logic                         m_axis_tuser    // [0] overflow
);

    localparam int SUM_W = stc_pkg::COL_W + 1;
    localparam int HI_W  = stc_pkg::COL_W - stc_pkg::TAB_SHIFT + 1;

    logic                        whole_line_reg;
    logic [stc_pkg::COL_W-1:0]   emitted_reg, emitted_next;
    logic [stc_pkg::COL_W-1:0]   pending_reg, pending_next;
    logic                        copying_reg, copying_next;
    logic                        sat_reg, sat_next;

    logic                        busy;
    logic                        accept;
    logic [stc_pkg::CHAR_W-1:0]  ch;
    logic                        is_space;
    logic                        is_tab;
    logic                        pend_at_max;
    logic [SUM_W-1:0]            pend_inc;
    logic [HI_W-1:0]             stop_hi;
    logic [SUM_W-1:0]            pend_stop;
    stc_pkg::job_t               job;

    assign pready = 1'b1;
    assign prdata = (paddr == stc_pkg::ADDR_WHOLE_LINE) ? {31'd0, whole_line_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_line_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && paddr == stc_pkg::ADDR_WHOLE_LINE)
        begin
            whole_line_reg <= pwdata[0];
        end
    end

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ch            = s_axis_tdata;
    assign is_space      = (ch == stc_pkg::CH_SPACE);
    assign is_tab        = (ch == stc_pkg::CH_TAB);
    assign pend_at_max   = (pending_reg == stc_pkg::COL_MAX);
    assign pend_inc      = {1'b0, pending_reg} + SUM_W'(1);
    assign stop_hi       = {1'b0, pending_reg[stc_pkg::COL_W-1:stc_pkg::TAB_SHIFT]}
                           + HI_W'(1);
    assign pend_stop     = {stop_hi, {stc_pkg::TAB_SHIFT{1'b0}}};

    always_comb
    begin
        emitted_next = emitted_reg;
        pending_next = pending_reg;
        copying_next = copying_reg;
        sat_next     = sat_reg;
        job.start    = 1'b0;
        job.ch       = ch;
        job.ocol     = emitted_reg;
        job.dcol     = pending_reg;
        job.ovf      = sat_reg;
        if (accept)
        begin
            if (copying_reg)
            begin
                // verbatim: no gap to close
                job.start = 1'b1;
                job.ocol  = '0;
                job.dcol  = '0;
            end
            else if (is_space)
            begin
                if (pend_inc > {1'b0, stc_pkg::COL_MAX})
                begin
                    pending_next = stc_pkg::COL_MAX;
                    sat_next     = 1'b1;
                end
                else
                begin
                    pending_next = pend_inc[stc_pkg::COL_W-1:0];
                end
            end
            else if (is_tab)
            begin
                if (pend_stop > {1'b0, stc_pkg::COL_MAX})
                begin
                    pending_next = stc_pkg::COL_MAX;
                    sat_next     = 1'b1;
                end
                else
                begin
                    pending_next = pend_stop[stc_pkg::COL_W-1:0];
                end
            end
            else
            begin
                job.start = 1'b1;
                if (ch != stc_pkg::CH_EOL)
                begin
                    if (whole_line_reg)
                    begin
                        if (pend_at_max)
                        begin
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            pending_next = pend_inc[stc_pkg::COL_W-1:0];
                        end
                        emitted_next = pending_next;
                    end
                    else
                    begin
                        emitted_next = pending_reg;
                        copying_next = 1'b1;
                    end
                end
                job.ovf = sat_next;
            end

            if (ch == stc_pkg::CH_EOL)
            begin
                emitted_next = '0;
                pending_next = '0;
                copying_next = 1'b0;
                sat_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitted_reg <= '0;
            pending_reg <= '0;
            copying_reg <= 1'b0;
            sat_reg     <= 1'b0;
        end
        else
        begin
            emitted_reg <= emitted_next;
            pending_reg <= pending_next;
            copying_reg <= copying_next;
            sat_reg     <= sat_next;
        end
    end

    stc_emitter u_emitter
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (job),
        .busy          (busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== design/stc_checker.sv =====
`default_nettype none

module stc_checker
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_axis_tvalid,
    input  wire                          s_axis_tready,
    input  wire  [stc_pkg::CHAR_W-1:0]   s_axis_tdata,
    input  wire                          m_axis_tvalid,
    input  wire                          m_axis_tready,
    input  wire  [stc_pkg::CHAR_W-1:0]   m_axis_tdata,
    input  wire                          m_axis_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a non-blank byte always produces results, so input closes behind it
    a_busy_after_text: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata != stc_pkg::CH_SPACE
        && s_axis_tdata != stc_pkg::CH_TAB |=> !s_axis_tready)
        else $error("input ready right after a text byte");

    // only fill characters come before the final result of a byte
    a_fill_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |->
        m_axis_tdata == stc_pkg::CH_TAB || m_axis_tdata == stc_pkg::CH_SPACE)
        else $error("non-fill character before last result");

    // results of one byte follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a result burst");

endmodule

bind space_to_tab_compressor_unit stc_checker u_stc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
